// ===== src/hale_pkg.sv =====
// ----------------------------------------------------------------------------
// hale_pkg
// shared types and character codes for the line encoder
// ----------------------------------------------------------------------------
`default_nettype none

package hale_pkg;

    // one result item
    typedef struct packed {
        logic [15:0] machine_word;
        logic        parse_error;
        logic [15:0] instruction_number;
    } t_result;

    // parser modes, one-hot
    typedef enum logic [10:0] {
        MODE_IDLE      = 11'b000_0000_0001,
        MODE_COMMENT   = 11'b000_0000_0010,
        MODE_LABEL     = 11'b000_0000_0100,
        MODE_AT_START  = 11'b000_0000_1000,
        MODE_AT_DIGITS = 11'b000_0001_0000,
        MODE_SYMBOL    = 11'b000_0010_0000,
        MODE_C_FIRST   = 11'b000_0100_0000,
        MODE_C_COMP    = 11'b000_1000_0000,
        MODE_JUMP0     = 11'b001_0000_0000,
        MODE_JUMP1     = 11'b010_0000_0000,
        MODE_JUMP2     = 11'b100_0000_0000
    } t_mode;

    // decoded comp field
    typedef struct packed {
        logic       ok;
        logic [6:0] bits;
    } t_comp;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    // dest bits
    localparam logic [2:0] DEST_A = 3'b100;
    localparam logic [2:0] DEST_D = 3'b010;
    localparam logic [2:0] DEST_M = 3'b001;

    // jump codes
    localparam logic [2:0] JMP_NULL = 3'b000;
    localparam logic [2:0] JMP_JGT  = 3'b001;
    localparam logic [2:0] JMP_JEQ  = 3'b010;
    localparam logic [2:0] JMP_JGE  = 3'b011;
    localparam logic [2:0] JMP_JLT  = 3'b100;
    localparam logic [2:0] JMP_JNE  = 3'b101;
    localparam logic [2:0] JMP_JLE  = 3'b110;
    localparam logic [2:0] JMP_JMP  = 3'b111;

    // top three bits of every c instruction
    localparam logic [2:0] C_PREFIX = 3'b111;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== src/hale_if.sv =====
// ----------------------------------------------------------------------------
// hale_if
// valid/ready channels for text bytes and encoded words
// ----------------------------------------------------------------------------
`default_nettype none

interface hale_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface hale_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] machine_word;
    logic        parse_error;
    logic [15:0] instruction_number;

    modport source (output valid, output machine_word, output parse_error,
                    output instruction_number, input ready);
    modport sink   (input valid, input machine_word, input parse_error,
                    input instruction_number, output ready);
endinterface

`default_nettype wire

// ===== src/hale_parser.sv =====
// ----------------------------------------------------------------------------
// hale_parser
// per-byte parse state and instruction encode, one byte per cycle while i_step is high
// ----------------------------------------------------------------------------
`default_nettype none

module hale_parser import hale_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_mode       r_mode, n_mode;
    logic [15:0] r_addr, n_addr;
    logic [2:0]  r_dest_seen, n_dest_seen;
    logic [2:0]  r_dest_final, n_dest_final;
    logic [7:0]  r_comp [3];
    logic [7:0]  n_comp [3];
    logic [1:0]  r_comp_cnt, n_comp_cnt;
    logic [7:0]  r_jump [2];
    logic [7:0]  n_jump [2];
    logic [15:0] r_count, n_count;
    logic        r_halted, n_halted;

    function automatic logic [2:0] dest_of(input logic [7:0] c);
        logic [2:0] d;
        d = 3'b000;
        if (c == CH_D) begin
            d = DEST_D;
        end else if (c == CH_M) begin
            d = DEST_M;
        end else if (c == CH_A) begin
            d = DEST_A;
        end
        return d;
    endfunction

    function automatic t_comp pick(input logic hit, input logic [6:0] v);
        t_comp r;
        r.ok   = hit;
        r.bits = hit ? v : 7'd0;
        return r;
    endfunction

    function automatic t_comp decode_comp(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2);
        t_comp r;
        r = '0;
        case (c0)
            CH_0: r = pick(1'b1, 7'b0101010);
            CH_1: r = pick(1'b1, 7'b0111111);
            CH_BANG: begin
                if (c1 == CH_M)      r = pick(1'b1, 7'h71);
                else if (c1 == CH_A) r = pick(1'b1, 7'h31);
                else if (c1 == CH_D) r = pick(1'b1, 7'h0D);
            end
            CH_MINUS: begin
                if (c1 == CH_M)      r = pick(1'b1, 7'h73);
                else if (c1 == CH_A) r = pick(1'b1, 7'h33);
                else if (c1 == CH_D) r = pick(1'b1, 7'h0F);
                else if (c1 == CH_1) r = pick(1'b1, 7'h3A);
            end
            CH_M: begin
                if (c1 == CH_PLUS) begin
                    if (c2 == CH_D)      r = pick(1'b1, 7'h42);
                    else if (c2 == CH_1) r = pick(1'b1, 7'h77);
                end else if (c1 == CH_MINUS) begin
                    if (c2 == CH_D)      r = pick(1'b1, 7'h47);
                    else if (c2 == CH_1) r = pick(1'b1, 7'h72);
                end else if (c1 == CH_AMP) begin
                    r = pick(1'b1, 7'h40);
                end else if (c1 == CH_BAR) begin
                    r = pick(1'b1, 7'h55);
                end else begin
                    r = pick(1'b1, 7'h70);
                end
            end
            CH_D: begin
                if (c1 == CH_PLUS) begin
                    if (c2 == CH_M)      r = pick(1'b1, 7'h42);
                    else if (c2 == CH_A) r = pick(1'b1, 7'h02);
                    else if (c2 == CH_1) r = pick(1'b1, 7'h1F);
                end else if (c1 == CH_MINUS) begin
                    if (c2 == CH_M)      r = pick(1'b1, 7'h53);
                    else if (c2 == CH_A) r = pick(1'b1, 7'h13);
                    else if (c2 == CH_1) r = pick(1'b1, 7'h0E);
                end else if (c1 == CH_AMP) begin
                    if (c2 == CH_M)      r = pick(1'b1, 7'h40);
                    else if (c2 == CH_A) r = pick(1'b1, 7'h00);
                end else if (c1 == CH_BAR) begin
                    if (c2 == CH_M)      r = pick(1'b1, 7'h55);
                    else if (c2 == CH_A) r = pick(1'b1, 7'h15);
                end else begin
                    r = pick(1'b1, 7'h0C);
                end
            end
            CH_A: begin
                if (c1 == CH_PLUS) begin
                    if (c2 == CH_D)      r = pick(1'b1, 7'h02);
                    else if (c2 == CH_1) r = pick(1'b1, 7'h37);
                end else if (c1 == CH_MINUS) begin
                    if (c2 == CH_D)      r = pick(1'b1, 7'h07);
                    else if (c2 == CH_1) r = pick(1'b1, 7'h32);
                end else if (c1 == CH_AMP) begin
                    r = pick(1'b1, 7'h00);
                end else if (c1 == CH_BAR) begin
                    r = pick(1'b1, 7'h15);
                end else begin
                    r = pick(1'b1, 7'h30);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] decode_jump(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        logic [2:0] j;
        j = JMP_NULL;
        if (a == CH_J) begin
            if (b == CH_G && c == CH_T)      j = JMP_JGT;
            else if (b == CH_E && c == CH_Q) j = JMP_JEQ;
            else if (b == CH_G && c == CH_E) j = JMP_JGE;
            else if (b == CH_L && c == CH_T) j = JMP_JLT;
            else if (b == CH_N && c == CH_E) j = JMP_JNE;
            else if (b == CH_L && c == CH_E) j = JMP_JLE;
            else if (b == CH_M && c == CH_P) j = JMP_JMP;
        end
        return j;
    endfunction

    logic        is_nul, is_space, is_eol, is_digit;
    logic [3:0]  digit;
    t_comp       comp;
    logic        do_start, do_rearm;
    logic [2:0]  jump_code;

    assign is_nul   = (i_byte == CH_NUL);
    assign is_space = !is_nul && (i_byte <= CH_SPACE);
    assign is_eol   = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit    = 4'(i_byte - CH_0);
    assign comp     = decode_comp(r_comp[0], r_comp[1], r_comp[2]);

    always_comb begin
        n_mode       = r_mode;
        n_addr       = r_addr;
        n_dest_seen  = r_dest_seen;
        n_dest_final = r_dest_final;
        n_comp       = r_comp;
        n_comp_cnt   = r_comp_cnt;
        n_jump       = r_jump;
        n_count      = r_count;
        n_halted     = r_halted;
        do_start     = 1'b0;
        do_rearm     = 1'b0;
        jump_code    = JMP_NULL;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.instruction_number = r_count;

        if (r_halted) begin
            do_rearm = is_nul;
        end else begin
            case (r_mode)
                MODE_COMMENT, MODE_LABEL: begin
                    if (is_nul) begin
                        do_rearm = 1'b1;
                    end else if (is_eol) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_SYMBOL: begin
                    if (is_nul) begin
                        do_rearm = 1'b1;
                    end else if (is_space) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_AT_START: begin
                    if (is_digit) begin
                        n_addr = 16'(digit);
                        n_mode = MODE_AT_DIGITS;
                    end else begin
                        // symbol reference encodes as address zero
                        o_res_valid = 1'b1;
                        if (is_nul) begin
                            do_rearm = 1'b1;
                        end else if (is_space) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            n_mode = MODE_SYMBOL;
                        end
                    end
                end
                MODE_AT_DIGITS: begin
                    if (is_digit) begin
                        n_addr = {r_addr[12:0], 3'b000} + {r_addr[14:0], 1'b0}
                               + 16'(digit);
                    end else begin
                        o_res_valid       = 1'b1;
                        o_res.machine_word = r_addr;
                        n_mode            = MODE_IDLE;
                        do_start          = 1'b1;
                    end
                end
                MODE_C_FIRST, MODE_C_COMP: begin
                    if (is_nul || is_eol || i_byte == CH_SEMI) begin
                        if (!comp.ok) begin
                            o_res_valid       = 1'b1;
                            o_res.parse_error = 1'b1;
                            n_mode            = MODE_IDLE;
                        end else if (i_byte == CH_SEMI) begin
                            n_mode = MODE_JUMP0;
                        end else begin
                            o_res_valid        = 1'b1;
                            o_res.machine_word = {C_PREFIX, comp.bits, r_dest_final,
                                                  JMP_NULL};
                            n_mode             = MODE_IDLE;
                        end
                        do_rearm = is_nul;
                    end else if (r_mode == MODE_C_FIRST && i_byte == CH_SLASH
                                 && r_comp_cnt == 2'd1 && r_comp[0] == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                    end else if (r_mode == MODE_C_FIRST && i_byte == CH_EQ) begin
                        n_dest_final = r_dest_seen;
                        n_comp[0]    = CH_NUL;
                        n_comp[1]    = CH_NUL;
                        n_comp[2]    = CH_NUL;
                        n_comp_cnt   = 2'd0;
                        n_mode       = MODE_C_COMP;
                    end else begin
                        if (r_mode == MODE_C_FIRST) begin
                            n_dest_seen = r_dest_seen | dest_of(i_byte);
                        end
                        if (r_comp_cnt != 2'd3) begin
                            n_comp[r_comp_cnt] = i_byte;
                            n_comp_cnt         = r_comp_cnt + 2'd1;
                        end
                    end
                end
                MODE_JUMP0, MODE_JUMP1, MODE_JUMP2: begin
                    if (is_nul || r_mode == MODE_JUMP2) begin
                        // comp already checked at the semicolon
                        if (!is_nul) begin
                            jump_code = decode_jump(r_jump[0], r_jump[1], i_byte);
                        end
                        o_res_valid        = 1'b1;
                        o_res.machine_word = {C_PREFIX, comp.bits, r_dest_final,
                                              jump_code};
                        n_mode             = MODE_IDLE;
                        do_rearm           = is_nul;
                    end else if (r_mode == MODE_JUMP0) begin
                        n_jump[0] = i_byte;
                        n_mode    = MODE_JUMP1;
                    end else begin
                        n_jump[1] = i_byte;
                        n_mode    = MODE_JUMP2;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
        end

        if (o_res_valid) begin
            if (o_res.parse_error) begin
                n_halted = 1'b1;
            end else if (r_count != COUNT_MAX) begin
                n_count = r_count + 16'd1;
            end
        end

        // start of a new command
        if (do_start) begin
            if (is_nul) begin
                do_rearm = 1'b1;
            end else if (is_space) begin
                n_mode = MODE_IDLE;
            end else if (i_byte == CH_AT) begin
                n_addr = 16'd0;
                n_mode = MODE_AT_START;
            end else if (i_byte == CH_LPAR) begin
                n_mode = MODE_LABEL;
            end else begin
                n_dest_seen  = dest_of(i_byte);
                n_dest_final = 3'b000;
                n_comp[0]    = i_byte;
                n_comp[1]    = CH_NUL;
                n_comp[2]    = CH_NUL;
                n_comp_cnt   = 2'd1;
                n_mode       = MODE_C_FIRST;
            end
        end

        if (do_rearm) begin
            n_mode       = MODE_IDLE;
            n_addr       = 16'd0;
            n_dest_seen  = 3'b000;
            n_dest_final = 3'b000;
            n_comp[0]    = CH_NUL;
            n_comp[1]    = CH_NUL;
            n_comp[2]    = CH_NUL;
            n_comp_cnt   = 2'd0;
            n_jump[0]    = CH_NUL;
            n_jump[1]    = CH_NUL;
            n_count      = 16'd1;
            n_halted     = 1'b0;
        end

        if (!i_step) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_addr       <= 16'd0;
            r_dest_seen  <= 3'b000;
            r_dest_final <= 3'b000;
            r_comp[0]    <= CH_NUL;
            r_comp[1]    <= CH_NUL;
            r_comp[2]    <= CH_NUL;
            r_comp_cnt   <= 2'd0;
            r_jump[0]    <= CH_NUL;
            r_jump[1]    <= CH_NUL;
            r_count      <= 16'd1;
            r_halted     <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_addr       <= n_addr;
            r_dest_seen  <= n_dest_seen;
            r_dest_final <= n_dest_final;
            r_comp       <= n_comp;
            r_comp_cnt   <= n_comp_cnt;
            r_jump       <= n_jump;
            r_count      <= n_count;
            r_halted     <= n_halted;
        end
    end

    // no result while halted on an error
    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_res_valid)
        else $error("result produced while halted");

    // an error not at end of text halts the parser
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.parse_error && !is_nul) |=> r_halted)
        else $error("error did not halt parser");

    // error results carry a zero word
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.parse_error) |-> (o_res.machine_word == 16'd0))
        else $error("error result with nonzero word");

endmodule

`default_nettype wire

// ===== src/hale_out_buf.sv =====
// ----------------------------------------------------------------------------
// hale_out_buf
// two-entry result buffer: output register plus skid slot
// ----------------------------------------------------------------------------
`default_nettype none

module hale_out_buf import hale_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    hale_word_if.source  o_word
);

    t_result r_head, n_head;
    t_result r_tail, n_tail;
    logic    r_head_v, n_head_v;
    logic    r_tail_v, n_tail_v;
    logic    pop;

    assign pop    = r_head_v && o_word.ready;
    assign o_full = r_tail_v;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_head_v = r_head_v;
        n_tail_v = r_tail_v;
        if (pop) begin
            if (r_tail_v) begin
                n_head   = r_tail;
                n_tail   = i_data;
                n_tail_v = i_push;
            end else begin
                n_head   = i_data;
                n_head_v = i_push;
            end
        end else if (i_push) begin
            if (r_head_v) begin
                n_tail   = i_data;
                n_tail_v = 1'b1;
            end else begin
                n_head   = i_data;
                n_head_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_tail_v <= n_tail_v;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_word.valid              = r_head_v;
    assign o_word.machine_word       = r_head.machine_word;
    assign o_word.parse_error        = r_head.parse_error;
    assign o_word.instruction_number = r_head.instruction_number;

    // skid slot only fills behind a full output register
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_v |-> r_head_v)
        else $error("skid slot valid with empty head");

endmodule

`default_nettype wire

// ===== src/hack_assembly_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// hack_assembly_line_encoder_top
// streaming assembler for hack assembly text, bytes in, words out
// ----------------------------------------------------------------------------
// Takes assembly source one byte per item on i_text and returns one 16-bit
// machine word per A or C instruction on o_word, together with a parse_error
// flag and the one-based instruction number (saturating at 65535). Whitespace,
// // comments and (label) lines are skipped; @digits encodes a decimal address
// modulo 65536 and @symbol encodes 0. A comp field that does not decode gives
// an error item with word 0, after which all bytes are dropped until byte 0.
// Byte 0 ends the text: it flushes any pending instruction and resets all
// parse state, so numbering restarts at 1. Throughput is one byte per clock
// while the output buffer is not full: the byte is captured in an input
// register, the parser updates its state and forms the result from that
// register, and the result lands in a two-entry output buffer. The input
// side stalls only while both buffer entries are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module hack_assembly_line_encoder_top import hale_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hale_byte_if.sink   i_text,
    hale_word_if.source o_word
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       buf_full;
    logic       step;
    logic       res_valid;
    t_result    res;

    // parser consumes the held byte whenever the buffer has a free slot
    assign step         = r_in_valid && !buf_full;
    assign i_text.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= (i_text.valid && i_text.ready) || (r_in_valid && !step);
        end
        if (i_text.valid && i_text.ready) begin
            r_in_byte <= i_text.text_byte;
        end
    end

    // parse state and encode
    hale_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register with skid slot
    hale_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_word  (o_word)
    );

    // never push a result into a full buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_valid && buf_full))
        else $error("result pushed into full buffer");

endmodule

`default_nettype wire

// ===== tb/sv/hack_assembly_line_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// hack_assembly_line_encoder_top_tb
// self-checking bench for the streaming hack assembly line encoder
// ----------------------------------------------------------------------------
// Feeds assembly text one byte per item and checks every returned word against
// a cycle-free model of the parser kept in this file. A short directed prologue
// touches address wrap, every jump name, comments, labels, symbols, lone slash,
// flush on end of text and the error halt. A random body of well-formed lines
// with random content, broken lines and raw noise follows. A short stretch
// near the end runs at full rate with the sink always ready. Both handshakes idle
// at random, with quiet stretches in between.
// ----------------------------------------------------------------------------

module hack_assembly_line_encoder_top_tb;
    import hale_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES   = 360;
    localparam int STEADY_LINES   = 10;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 1_000_000;

    // one text byte waiting to be sent, with the idle cycles that precede it
    typedef struct {
        logic [7:0]  text_byte;
        int unsigned gap;
        bit          steady;
    } t_text_item;

    logic i_clk;
    logic i_rst_n;

    hale_byte_if text_if ();
    hale_word_if word_if ();

    hack_assembly_line_encoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_word  (word_if)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_text_item pending_bytes [$];
    t_result    expected_words [$];
    int         total_bytes;
    int         bytes_taken;
    int         mismatch_count;
    int         cycle_count;
    int unsigned gap_waited;
    int unsigned stall_left;
    bit         byte_taken;
    bit         front_steady;
    bit         steady_flow;
    bit         sink_calm;
    bit         steady_mode;
    int         calm_left;

    // ------------------------------------------------------------------------
    // parser model: mirrors the block's state, one call per accepted byte
    // ------------------------------------------------------------------------
    t_mode       asm_mode;
    logic [15:0] addr_value;
    logic [2:0]  dest_pending;
    logic [2:0]  dest_taken;
    logic [7:0]  comp_text [3];
    logic [1:0]  comp_len;
    logic [7:0]  jump_text [2];
    logic [15:0] instr_num;
    bit          halted;

    function automatic bit is_blank(input logic [7:0] b);
        return b >= 8'd1 && b <= CH_SPACE;
    endfunction

    function automatic bit is_eol(input logic [7:0] b);
        return b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    // a+c field from the first three comp characters, unused ones are zero
    function automatic t_comp comp_field(input logic [7:0] c0, c1, c2);
        t_comp r;
        r.ok   = 1'b1;
        r.bits = 7'h00;
        case (c0)
            CH_0: r.bits = 7'h2A;
            CH_1: r.bits = 7'h3F;
            CH_BANG: begin
                case (c1)
                    CH_M:    r.bits = 7'h71;
                    CH_A:    r.bits = 7'h31;
                    CH_D:    r.bits = 7'h0D;
                    default: r.ok = 1'b0;
                endcase
            end
            CH_MINUS: begin
                case (c1)
                    CH_M:    r.bits = 7'h73;
                    CH_A:    r.bits = 7'h33;
                    CH_D:    r.bits = 7'h0F;
                    CH_1:    r.bits = 7'h3A;
                    default: r.ok = 1'b0;
                endcase
            end
            CH_M: begin
                case (c1)
                    CH_PLUS: begin
                        if (c2 == CH_D) r.bits = 7'h42;
                        else if (c2 == CH_1) r.bits = 7'h77;
                        else r.ok = 1'b0;
                    end
                    CH_MINUS: begin
                        if (c2 == CH_D) r.bits = 7'h47;
                        else if (c2 == CH_1) r.bits = 7'h72;
                        else r.ok = 1'b0;
                    end
                    CH_AMP:  r.bits = 7'h40;
                    CH_BAR:  r.bits = 7'h55;
                    default: r.bits = 7'h70;
                endcase
            end
            CH_D: begin
                case (c1)
                    CH_PLUS: begin
                        if (c2 == CH_M) r.bits = 7'h42;
                        else if (c2 == CH_A) r.bits = 7'h02;
                        else if (c2 == CH_1) r.bits = 7'h1F;
                        else r.ok = 1'b0;
                    end
                    CH_MINUS: begin
                        if (c2 == CH_M) r.bits = 7'h53;
                        else if (c2 == CH_A) r.bits = 7'h13;
                        else if (c2 == CH_1) r.bits = 7'h0E;
                        else r.ok = 1'b0;
                    end
                    CH_AMP: begin
                        if (c2 == CH_M) r.bits = 7'h40;
                        else if (c2 == CH_A) r.bits = 7'h00;
                        else r.ok = 1'b0;
                    end
                    CH_BAR: begin
                        if (c2 == CH_M) r.bits = 7'h55;
                        else if (c2 == CH_A) r.bits = 7'h15;
                        else r.ok = 1'b0;
                    end
                    default: r.bits = 7'h0C;
                endcase
            end
            CH_A: begin
                case (c1)
                    CH_PLUS: begin
                        if (c2 == CH_D) r.bits = 7'h02;
                        else if (c2 == CH_1) r.bits = 7'h37;
                        else r.ok = 1'b0;
                    end
                    CH_MINUS: begin
                        if (c2 == CH_D) r.bits = 7'h07;
                        else if (c2 == CH_1) r.bits = 7'h32;
                        else r.ok = 1'b0;
                    end
                    CH_AMP:  r.bits = 7'h00;
                    CH_BAR:  r.bits = 7'h15;
                    default: r.bits = 7'h30;
                endcase
            end
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] jump_code(input logic [7:0] j0, j1, j2);
        if (j0 != CH_J) return JMP_NULL;
        case ({j1, j2})
            {CH_G, CH_T}: return JMP_JGT;
            {CH_E, CH_Q}: return JMP_JEQ;
            {CH_G, CH_E}: return JMP_JGE;
            {CH_L, CH_T}: return JMP_JLT;
            {CH_N, CH_E}: return JMP_JNE;
            {CH_L, CH_E}: return JMP_JLE;
            {CH_M, CH_P}: return JMP_JMP;
            default:      return JMP_NULL;
        endcase
    endfunction

    task automatic clear_comp();
        comp_text[0] = CH_NUL;
        comp_text[1] = CH_NUL;
        comp_text[2] = CH_NUL;
        comp_len     = 2'd0;
    endtask

    // back to the state after reset, numbering restarts at one
    task automatic clear_parse();
        asm_mode     = MODE_IDLE;
        addr_value   = 16'h0000;
        dest_pending = 3'b000;
        dest_taken   = 3'b000;
        clear_comp();
        jump_text[0] = CH_NUL;
        jump_text[1] = CH_NUL;
        instr_num    = 16'd1;
        halted       = 1'b0;
    endtask

    task automatic take_comp_char(input logic [7:0] b);
        if (comp_len != 2'd3) begin
            comp_text[comp_len] = b;
            comp_len = comp_len + 2'd1;
        end
    endtask

    task automatic note_dest(input logic [7:0] b);
        if (b == CH_D) dest_pending |= DEST_D;
        else if (b == CH_M) dest_pending |= DEST_M;
        else if (b == CH_A) dest_pending |= DEST_A;
    endtask

    task automatic push_word(input logic [15:0] word, input logic err);
        t_result r;
        r.machine_word       = word;
        r.parse_error        = err;
        r.instruction_number = instr_num;
        expected_words.push_back(r);
        if (err) halted = 1'b1;
        else if (instr_num != COUNT_MAX) instr_num = instr_num + 16'd1;
        asm_mode = MODE_IDLE;
    endtask

    task automatic close_c(input logic [2:0] jmp);
        t_comp c;
        c = comp_field(comp_text[0], comp_text[1], comp_text[2]);
        if (c.ok) push_word({C_PREFIX, c.bits, dest_taken, jmp}, 1'b0);
        else push_word(16'h0000, 1'b1);
    endtask

    // first byte of a command, never gives a word
    task automatic begin_command(input logic [7:0] b);
        if (b == CH_NUL) begin
            clear_parse();
        end else if (is_blank(b)) begin
            asm_mode = MODE_IDLE;
        end else if (b == CH_AT) begin
            addr_value = 16'h0000;
            asm_mode   = MODE_AT_START;
        end else if (b == CH_LPAR) begin
            asm_mode = MODE_LABEL;
        end else begin
            dest_pending = 3'b000;
            dest_taken   = 3'b000;
            clear_comp();
            asm_mode = MODE_C_FIRST;
            note_dest(b);
            take_comp_char(b);
        end
    endtask

    task automatic encode_byte(input logic [7:0] b);
        t_comp c;
        if (halted) begin
            // everything is dropped until end of text
            if (b == CH_NUL) clear_parse();
        end else begin
            case (asm_mode)
                MODE_COMMENT, MODE_LABEL: begin
                    if (b == CH_NUL) clear_parse();
                    else if (is_eol(b)) asm_mode = MODE_IDLE;
                end
                MODE_SYMBOL: begin
                    if (b == CH_NUL) clear_parse();
                    else if (is_blank(b)) asm_mode = MODE_IDLE;
                end
                MODE_AT_START: begin
                    if (is_digit(b)) begin
                        addr_value = 16'(b - CH_0);
                        asm_mode   = MODE_AT_DIGITS;
                    end else begin
                        // symbol or bare @ gives address zero
                        push_word(16'h0000, 1'b0);
                        if (b == CH_NUL) clear_parse();
                        else if (!is_blank(b)) asm_mode = MODE_SYMBOL;
                    end
                end
                MODE_AT_DIGITS: begin
                    if (is_digit(b)) begin
                        addr_value = addr_value * 16'd10 + 16'(b - CH_0);
                    end else begin
                        push_word(addr_value, 1'b0);
                        begin_command(b);
                    end
                end
                MODE_C_FIRST, MODE_C_COMP: begin
                    if (b == CH_NUL || is_eol(b)) begin
                        close_c(JMP_NULL);
                        if (b == CH_NUL) clear_parse();
                    end else if (b == CH_SEMI) begin
                        c = comp_field(comp_text[0], comp_text[1], comp_text[2]);
                        if (!c.ok) push_word(16'h0000, 1'b1);
                        else asm_mode = MODE_JUMP0;
                    end else if (asm_mode == MODE_C_FIRST && b == CH_SLASH &&
                                 comp_len == 2'd1 && comp_text[0] == CH_SLASH) begin
                        asm_mode = MODE_COMMENT;
                    end else if (asm_mode == MODE_C_FIRST && b == CH_EQ) begin
                        dest_taken = dest_pending;
                        clear_comp();
                        asm_mode = MODE_C_COMP;
                    end else begin
                        if (asm_mode == MODE_C_FIRST) note_dest(b);
                        take_comp_char(b);
                    end
                end
                MODE_JUMP0, MODE_JUMP1: begin
                    if (b == CH_NUL) begin
                        close_c(JMP_NULL);
                        clear_parse();
                    end else if (asm_mode == MODE_JUMP0) begin
                        jump_text[0] = b;
                        asm_mode     = MODE_JUMP1;
                    end else begin
                        jump_text[1] = b;
                        asm_mode     = MODE_JUMP2;
                    end
                end
                MODE_JUMP2: begin
                    if (b == CH_NUL) begin
                        close_c(JMP_NULL);
                        clear_parse();
                    end else begin
                        close_c(jump_code(jump_text[0], jump_text[1], b));
                    end
                end
                default: begin_command(b);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // text generation
    // ------------------------------------------------------------------------
    string good_comps [34] = '{"0", "1", "-1", "D", "A", "M", "!D", "!A", "!M",
                               "-D", "-A", "-M", "D+1", "A+1", "M+1", "D-1", "A-1",
                               "M-1", "D+A", "D+M", "A+D", "M+D", "D-A", "D-M",
                               "A-D", "M-D", "D&A", "D&M", "A&D", "M&D", "D|A",
                               "D|M", "A|D", "M|D"};
    string bad_comps [14]  = '{"X", "+1", "!X", "-X", "M+X", "A-Q", "D&1", "D|1",
                               "D+", " D", "/", "=D", "!", "-"};
    string jump_names [10] = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP",
                               "JXX", "XMP", "JG\n"};
    string dest_names [10] = '{"A", "D", "M", "AM", "AD", "MD", "AMD", "DMA", "MM",
                               "X"};
    string c_ends [3]      = '{"\n", "\r\n", "\r"};
    string at_ends [5]     = '{"\n", "\r\n", " ", "\t", ""};
    string cut_short [11]  = '{"", "D=M", "AM=M+1;J", "0;JG", "@123", "@", "@x",
                               "(lab", "// c", "D;JEQ", "M=D+"};
    string symbol_pool     = "abcxyzLOOP_.$:R";

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        t_text_item it;
        it.text_byte = b;
        it.steady    = steady_mode;
        if (steady_mode || calm_left > 0) it.gap = 0;
        else it.gap = pick_gap();
        if (calm_left > 0) calm_left--;
        pending_bytes.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_symbol();
        repeat ($urandom_range(1, 6))
            add_byte(symbol_pool[$urandom_range(0, symbol_pool.len() - 1)]);
    endtask

    function automatic string number_text();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4) return $sformatf("%0d", $urandom_range(0, 99));
        if (k < 7) return $sformatf("%0d", $urandom_range(0, 65535));
        if (k < 9) return $sformatf("%0d", $urandom_range(65536, 999999));
        return $sformatf("00%0d", $urandom_range(0, 9));
    endfunction

    task automatic queue_random_line();
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
        if (r < 20) begin
            add_text({"@", number_text(), at_ends[$urandom_range(0, 4)]});
        end else if (r < 25) begin
            add_text("@");
            if ($urandom_range(0, 3) != 0) add_symbol();
            add_text($urandom_range(0, 1) ? " " : "\n");
        end else if (r < 60) begin
            // well-formed c instruction with random fields
            if ($urandom_range(0, 1)) add_text({dest_names[$urandom_range(0, 9)], "="});
            add_text(good_comps[$urandom_range(0, 33)]);
            if ($urandom_range(0, 1)) add_text({";", jump_names[$urandom_range(0, 9)]});
            add_text(c_ends[$urandom_range(0, 2)]);
        end else if (r < 66) begin
            add_text("//");
            repeat ($urandom_range(0, 8)) begin
                c = 8'($urandom_range(1, 255));
                add_byte(is_eol(c) ? CH_SPACE : c);
            end
            add_text("\n");
        end else if (r < 70) begin
            add_text("(");
            add_symbol();
            add_text(")\n");
        end else if (r < 80) begin
            // end of text, often in the middle of a command
            add_text(cut_short[$urandom_range(0, 10)]);
            add_byte(CH_NUL);
        end else if (r < 87) begin
            // broken comp, some bytes that are dropped, then rearm
            if ($urandom_range(0, 1)) add_text({dest_names[$urandom_range(0, 9)], "="});
            add_text(bad_comps[$urandom_range(0, 13)]);
            add_text($urandom_range(0, 1) ? ";JMP" : "\n");
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(1, 255)));
            add_byte(CH_NUL);
        end else begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            add_text("\n");
        end
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // text driver: presents queued bytes at the falling edge, honoring gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
        end else if (!text_if.valid || byte_taken) begin
            if (pending_bytes.size() == 0) begin
                text_if.valid <= 1'b0;
            end else if (gap_waited < pending_bytes[0].gap) begin
                text_if.valid <= 1'b0;
                gap_waited <= gap_waited + 1;
            end else begin
                text_if.valid     <= 1'b1;
                text_if.text_byte <= pending_bytes[0].text_byte;
                front_steady      <= pending_bytes[0].steady;
                gap_waited        <= 0;
                void'(pending_bytes.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // word sink: random back-pressure, off during steady and calm stretches
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
        end else begin
            if (steady_flow) begin
                word_if.ready <= 1'b1;
                stall_left    <= 0;
            end else if (stall_left > 0) begin
                word_if.ready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
                word_if.ready <= 1'b0;
                stall_left    <= pick_gap();
            end else begin
                word_if.ready <= 1'b1;
            end
            if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: model update on each accepted byte, check on each accepted word
    // ------------------------------------------------------------------------
    task automatic check_word();
        t_result want;
        if (expected_words.size() == 0) begin
            $error("unexpected item: machine_word %h parse_error %b instruction_number %0d",
                   word_if.machine_word, word_if.parse_error, word_if.instruction_number);
            mismatch_count++;
        end else begin
            want = expected_words.pop_front();
            if (word_if.machine_word !== want.machine_word) begin
                $error("machine_word: expected %h, got %h",
                       want.machine_word, word_if.machine_word);
                mismatch_count++;
            end
            if (word_if.parse_error !== want.parse_error) begin
                $error("parse_error: expected %b, got %b",
                       want.parse_error, word_if.parse_error);
                mismatch_count++;
            end
            if (word_if.instruction_number !== want.instruction_number) begin
                $error("instruction_number: expected %0d, got %0d",
                       want.instruction_number, word_if.instruction_number);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        byte_taken <= i_rst_n && text_if.valid && text_if.ready;
        if (!i_rst_n) begin
            clear_parse();
        end else begin
            if (text_if.valid && text_if.ready) begin
                encode_byte(text_if.text_byte);
                bytes_taken <= bytes_taken + 1;
                steady_flow <= front_steady;
            end
            if (word_if.valid && word_if.ready) check_word();
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int start;
        text_if.valid     = 1'b0;
        text_if.text_byte = 8'h00;
        word_if.ready     = 1'b0;
        i_rst_n           = 1'b0;
        bytes_taken       = 0;
        mismatch_count    = 0;
        cycle_count       = 0;
        gap_waited        = 0;
        stall_left        = 0;
        byte_taken        = 1'b0;
        front_steady      = 1'b0;
        steady_flow       = 1'b0;
        sink_calm         = 1'b0;
        steady_mode       = 1'b0;
        calm_left         = 0;

        // addresses: zero, top, wrap, large wrap, number ended by next command
        add_text("@0\n@65535\n@65536\n@99999 @7D=A\n");
        // symbol, bare @, label and comment lines
        add_text("@sym\n@\n(LOOP)\n// note\n");
        // all dests at once and every jump name, plus one that matches nothing
        add_text("AMD=D|A;JMP\n0;JGT\nD;JEQ\nM;JGE\nA;JLT\nD;JNE\nD;JLE\nD+1;JXX\n");
        add_text("  \tM=!M\r\n");
        // high bytes inside a comment, then one as a command of its own
        add_text("//");
        add_byte(8'hFF);
        add_byte(8'h80);
        add_text("\n");
        add_byte(8'hC3);
        add_text("\n@4\n");
        add_byte(CH_NUL);
        // end of text flushes a c instruction, an unfinished jump and a bare @
        add_text("D=M");
        add_byte(CH_NUL);
        add_text("0;J");
        add_byte(CH_NUL);
        add_text("@");
        add_byte(CH_NUL);
        // lone slash, comp starting with a space, comp cut short before ';'
        add_text("/D\n@5\n");
        add_byte(CH_NUL);
        add_text("M= D\n");
        add_byte(CH_NUL);
        add_text("M=D+;JMP\n");
        add_byte(CH_NUL);

        start = pending_bytes.size();
        while (pending_bytes.size() - start < RANDOM_BYTES) queue_random_line();

        // short stretch at full rate with the sink always ready
        steady_mode = 1'b1;
        add_byte(CH_NUL);
        repeat (STEADY_LINES) add_text("1\n");
        add_text("@5\n");
        add_byte(CH_NUL);
        steady_mode = 1'b0;
        add_text("@3\n");

        total_bytes = pending_bytes.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != total_bytes || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
